@@ rtl/core/bb3_pkg.sv @@
// Shared widths, register codes and the divide-by-nine helper for the 3x3 box blur.
package bb3_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int COL_OUT_W = 7;
  localparam int FW_W = 8;
  localparam int FH_W = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int DEFAULT_MAX_WIDTH = 128;

  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(128);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(128);

  localparam int COLSUM_W = PIX_W + 2;
  localparam int SUM_W = PIX_W + 4;
  localparam int DIV_K = SUM_W + 4;
  localparam int DIV_M = ((2 ** DIV_K) + 8) / 9;
  localparam int PROD_W = SUM_W + DIV_K;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = CFG_IDX_W'(0),
    REG_FRAME_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_e;

  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(DIV_M);
    return prod[DIV_K +: PIX_W];
  endfunction

endpackage

@@ rtl/core/box_blur_3x3_border_keep.sv @@
// Top level of the 3x3 box-mean filter with the frame border passed through.
//
// Pixels arrive on the s_axis stream in raster order, one 8-bit pixel per
// transaction. Frame size comes from two registers written over the cfg
// channel (index 0: width, index 1: height); any such write restarts the
// frame at row 0, column 0. Results leave on the m_axis stream with their
// row, column and value; tlast marks the final result caused by one pixel.
// A border pixel is sent as it arrives; an interior pixel is sent as the
// floor of its 3x3 sum over nine once the pixel below-right of it arrives.
// A result goes through the input stage and then output register a or b.
// Throughput: one pixel per clock while the receiver takes every result.
// A pixel in the last column from row two on, or in the last row from
// column two on, causes two results; they leave one at a time on the
// single output port, and the input waits meanwhile. Two line stores hold
// the previous two rows, each read at the incoming column.
// Reset: frame size 128 x 128, position row 0 column 0, stages empty.
// When the receiver stalls, results hold, one pixel waits in the input
// stage, and s_axis_tready then drops until the output moves again.
module box_blur_3x3_border_keep #(
  parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bb3_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] pixel_in
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [11:0] out_row, [18:12] out_col, [26:19] out_value, [31:27] zero
  output logic [bb3_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,  // last_of_item
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bb3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WID_W > FW_W) ? WID_W : FW_W;
  localparam int HEI_W = FH_W;

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [WID_W-1:0] eff_w;
  logic [HEI_W-1:0] eff_h;
  logic [CMP_W-1:0] fw_ext;

  logic [COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;
  logic             col_wrap, row_wrap;

  logic             in_hs, m_hs, cfg_hs, cfg_hit;
  logic             s1_go, out_free;

  logic             s1_v_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_int_q, s1_brd_q;
  logic [PIX_W-1:0] up_q, lo_q;
  logic             in_int, in_brd;

  logic [PIX_W-1:0] upper_mem_q [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem_q [MAX_WIDTH];

  logic [COLSUM_W-1:0] cs1_q, cs2_q, new_col;
  logic [SUM_W-1:0]    win_sum;

  logic                 a_v_q, b_v_q;
  logic [ROW_W-1:0]     a_row_q, b_row_q;
  logic [COL_OUT_W-1:0] a_col_q, b_col_q;
  logic [PIX_W-1:0]     a_val_q, b_val_q;

  logic [ROW_W-1:0]     sel_row;
  logic [COL_OUT_W-1:0] sel_col;
  logic [PIX_W-1:0]     sel_val;

  assign fw_ext = CMP_W'(fw_q);

  always_comb begin
    if (fw_q == '0) begin
      eff_w = WID_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(fw_q);
    end
    if (fh_q == '0) begin
      eff_h = HEI_W'(1);
    end else if (fh_q > HEI_W'(MAX_HEIGHT)) begin
      eff_h = HEI_W'(MAX_HEIGHT);
    end else begin
      eff_h = fh_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_hs = cfg_valid_i & cfg_ready_o;
  assign cfg_hit = cfg_hs && (cfg_index_i == REG_FRAME_WIDTH ||
                              cfg_index_i == REG_FRAME_HEIGHT);

  assign out_free = (!a_v_q && !b_v_q) || (m_hs && !(a_v_q && b_v_q));
  assign s1_go = s1_v_q && out_free;
  assign s_axis_tready = !s1_v_q || s1_go;
  assign in_hs = s_axis_tvalid & s_axis_tready;
  assign m_hs = m_axis_tvalid & m_axis_tready;

  assign col_wrap = (WID_W'(col_cnt_q) + WID_W'(1)) >= eff_w;
  assign row_wrap = (HEI_W'(row_cnt_q) + HEI_W'(1)) >= eff_h;
  assign in_int = (row_cnt_q >= ROW_W'(2)) && (col_cnt_q >= COL_W'(2));
  assign in_brd = (row_cnt_q == '0) || row_wrap || (col_cnt_q == '0) || col_wrap;

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (cfg_hit) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (in_hs) begin
      if (col_wrap) begin
        col_cnt_d = '0;
        row_cnt_d = row_wrap ? '0 : row_cnt_q + ROW_W'(1);
      end else begin
        col_cnt_d = col_cnt_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= FW_RESET;
      fh_q      <= FH_RESET;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
    end else begin
      if (cfg_hs) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
          REG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      if (in_hs) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        a_v_q <= s1_int_q;
        b_v_q <= s1_brd_q;
      end else if (m_hs) begin
        if (a_v_q) begin
          a_v_q <= 1'b0;
        end else begin
          b_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      s1_pix_q <= s_axis_tdata[PIX_W-1:0];
      s1_row_q <= row_cnt_q;
      s1_col_q <= col_cnt_q;
      s1_int_q <= in_int;
      s1_brd_q <= in_brd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      upper_mem_q[s1_col_q] <= lo_q;
    end
    if (in_hs) begin
      up_q <= upper_mem_q[col_cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      lower_mem_q[col_cnt_q] <= s_axis_tdata[PIX_W-1:0];
      lo_q <= lower_mem_q[col_cnt_q];
    end
  end

  assign new_col = COLSUM_W'(up_q) + COLSUM_W'(lo_q) + COLSUM_W'(s1_pix_q);
  assign win_sum = SUM_W'(cs1_q) + SUM_W'(cs2_q) + SUM_W'(new_col);

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      cs1_q   <= cs2_q;
      cs2_q   <= new_col;
      a_row_q <= s1_row_q - ROW_W'(1);
      a_col_q <= COL_OUT_W'(s1_col_q - COL_W'(1));
      a_val_q <= div9(win_sum);
      b_row_q <= s1_row_q;
      b_col_q <= COL_OUT_W'(s1_col_q);
      b_val_q <= s1_pix_q;
    end
  end

  assign sel_row = a_v_q ? a_row_q : b_row_q;
  assign sel_col = a_v_q ? a_col_q : b_col_q;
  assign sel_val = a_v_q ? a_val_q : b_val_q;

  assign m_axis_tvalid = a_v_q | b_v_q;
  assign m_axis_tlast  = a_v_q ? !b_v_q : 1'b1;
  assign m_axis_tdata  = {(OUT_DATA_W - ROW_W - COL_OUT_W - PIX_W)'(0),
                          sel_val, sel_col, sel_row};

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WID_W'(col_cnt_q) < eff_w)
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HEI_W'(row_cnt_q) < eff_h)
    else $error("row counter beyond frame height");

  a_pair_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q && b_v_q |-> b_row_q == a_row_q + ROW_W'(1))
    else $error("interior and border results of one pixel on unrelated rows");

  a_interior_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q |-> a_row_q != '0)
    else $error("interior result on the first row");
`endif

endmodule
